>>> hdl/vsld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vsld_pkg;

	// parse phase, one-hot
	typedef enum logic [6:0] {
		PH_HDR0  = 7'b0000001,
		PH_HDR1  = 7'b0000010,
		PH_HDR2  = 7'b0000100,
		PH_HDR3  = 7'b0001000,
		PH_COPY  = 7'b0010000,
		PH_FILL0 = 7'b0100000,
		PH_FILL1 = 7'b1000000
	} phase_t;

	localparam int unsigned REM_BITS   = 15;
	localparam int unsigned COUNT_BITS = 14;

	localparam logic [1:0] LANE_NONE = 2'b00;
	localparam logic [1:0] LANE_LOW  = 2'b01;
	localparam logic [1:0] LANE_BOTH = 2'b11;

	localparam int unsigned END_BIT    = 7;  // first header byte: end of list
	localparam int unsigned STRIDE_BIT = 7;  // third header byte
	localparam int unsigned FILL_BIT   = 6;  // third header byte

	typedef struct packed {
		logic [15:0]           word_address;
		logic [15:0]           write_data;
		logic [1:0]            lane_enable;
		logic [COUNT_BITS-1:0] repeat_count;
		logic                  stride_is_32;
		logic                  list_done;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/vram_stripe_list_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stripe upload list decoder.
// Input channel: list_byte with in_valid/in_stall, one list byte per transaction,
// record headers and data bytes in list order.
// Output channel: one video memory write command per transaction (word_address,
// write_data, lane_enable, repeat_count, stride_is_32, list_done) with
// out_valid/out_stall. Header bytes and the first byte of each word produce
// nothing; the second byte of a word, an odd tail byte, the second fill byte
// and the end marker each produce one command.
// Throughput: one byte per cycle while in_stall is low. An accepted byte passes
// through the input register, then the result register, on its way to the outputs.
// A skid register behind the result register absorbs one command while the
// receiver stalls; the input stalls only while that skid register is full and a
// byte is waiting in the input register.
// Reset clears the parser to await a first header byte, with address, length
// and packing state zeroed, and empties all pipeline registers.
module vram_stripe_list_decoder_unit #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  list_byte,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [15:0] word_address,
	output      logic [15:0] write_data,
	output      logic [1:0]  lane_enable,
	output      logic [13:0] repeat_count,
	output      logic        stride_is_32,
	output      logic        list_done
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              core_valid;
	vsld_pkg::result_t core_res;
	logic              out_valid_q;
	vsld_pkg::result_t out_q;
	logic              skid_valid_q;
	vsld_pkg::result_t skid_q;
	logic              pop;

	assign advance  = valid_s1 && !skid_valid_q;
	assign in_stall = valid_s1 && skid_valid_q;
	assign pop      = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= list_byte;
		end
	end

	vsld_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.step_byte (byte_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	// result register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= core_valid;
		end else if (core_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= core_res;
		end else if (core_valid) begin
			skid_q <= core_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign word_address = out_q.word_address;
	assign write_data   = out_q.write_data;
	assign lane_enable  = out_q.lane_enable;
	assign repeat_count = out_q.repeat_count;
	assign stride_is_32 = out_q.stride_is_32;
	assign list_done    = out_q.list_done;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a command while result register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !skid_valid_q && core_valid) |=> skid_valid_q)
		else $error("command lost while output stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && list_done) |-> (lane_enable == vsld_pkg::LANE_NONE
			&& repeat_count == 14'd0 && word_address == 16'd0 && write_data == 16'd0))
		else $error("end marker command carries nonzero fields");

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !list_done) |-> (repeat_count != 14'd0
			&& lane_enable != vsld_pkg::LANE_NONE))
		else $error("write command with no words or no lanes");

endmodule

`default_nettype wire

>>> hdl/vsld_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Parser state and the per-byte update. One byte per enabled cycle,
// at most one write command out.
module vsld_core #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic [7:0]        step_byte,
	output      logic              res_valid,
	output      vsld_pkg::result_t res
);

	vsld_pkg::phase_t                 phase_q, phase_d;
	logic [ADDR_BITS-1:0]             addr_q, addr_d, addr_step;
	logic                             stride_q, stride_d;
	logic                             fill_q, fill_d;
	logic [vsld_pkg::REM_BITS-1:0]    rem_q, rem_d, rem_dec;
	logic [7:0]                       held_q, held_d;
	logic                             parity_q, parity_d;
	logic [15:0]                      addr_out;

	assign addr_step = addr_q + (stride_q ? ADDR_BITS'(32) : ADDR_BITS'(1));
	assign rem_dec   = rem_q - vsld_pkg::REM_BITS'(1);
	assign addr_out  = 16'(addr_q);

	always_comb begin
		phase_d   = phase_q;
		addr_d    = addr_q;
		stride_d  = stride_q;
		fill_d    = fill_q;
		rem_d     = rem_q;
		held_d    = held_q;
		parity_d  = parity_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			vsld_pkg::PH_HDR1: begin
				addr_d  = addr_q | ADDR_BITS'(step_byte);
				phase_d = vsld_pkg::PH_HDR2;
			end
			vsld_pkg::PH_HDR2: begin
				stride_d = step_byte[vsld_pkg::STRIDE_BIT];
				fill_d   = step_byte[vsld_pkg::FILL_BIT];
				rem_d    = {1'b0, step_byte[5:0], 8'h00};
				phase_d  = vsld_pkg::PH_HDR3;
			end
			vsld_pkg::PH_HDR3: begin
				// length minus one -> byte count
				rem_d    = {1'b0, rem_q[13:8], step_byte} + vsld_pkg::REM_BITS'(1);
				parity_d = 1'b0;
				held_d   = 8'h00;
				phase_d  = fill_q ? vsld_pkg::PH_FILL0 : vsld_pkg::PH_COPY;
			end
			vsld_pkg::PH_COPY: begin
				rem_d = rem_dec;
				if (parity_q) begin
					res_valid        = 1'b1;
					res.word_address = addr_out;
					res.write_data   = {step_byte, held_q};
					res.lane_enable  = vsld_pkg::LANE_BOTH;
					res.repeat_count = vsld_pkg::COUNT_BITS'(1);
					res.stride_is_32 = stride_q;
					parity_d         = 1'b0;
					addr_d           = addr_step;
					if (rem_dec == '0) begin
						phase_d = vsld_pkg::PH_HDR0;
					end
				end else if (rem_dec == '0) begin
					// odd tail: low lane only
					res_valid        = 1'b1;
					res.word_address = addr_out;
					res.write_data   = {8'h00, step_byte};
					res.lane_enable  = vsld_pkg::LANE_LOW;
					res.repeat_count = vsld_pkg::COUNT_BITS'(1);
					res.stride_is_32 = stride_q;
					addr_d           = addr_step;
					phase_d          = vsld_pkg::PH_HDR0;
				end else begin
					held_d   = step_byte;
					parity_d = 1'b1;
				end
			end
			vsld_pkg::PH_FILL0: begin
				held_d   = step_byte;
				parity_d = 1'b1;
				phase_d  = vsld_pkg::PH_FILL1;
			end
			vsld_pkg::PH_FILL1: begin
				res_valid        = 1'b1;
				res.word_address = addr_out;
				res.write_data   = {step_byte, held_q};
				res.lane_enable  = vsld_pkg::LANE_BOTH;
				res.repeat_count = vsld_pkg::COUNT_BITS'((rem_q + vsld_pkg::REM_BITS'(1)) >> 1);
				res.stride_is_32 = stride_q;
				parity_d         = 1'b0;
				rem_d            = '0;
				phase_d          = vsld_pkg::PH_HDR0;
			end
			default: begin
				if (step_byte[vsld_pkg::END_BIT]) begin
					res_valid      = 1'b1;
					res.list_done  = 1'b1;
					res.lane_enable = vsld_pkg::LANE_NONE;
					phase_d        = vsld_pkg::PH_HDR0;
				end else begin
					addr_d  = ADDR_BITS'({step_byte, 8'h00});
					phase_d = vsld_pkg::PH_HDR1;
				end
			end
		endcase
		if (!step_en) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vsld_pkg::PH_HDR0;
			addr_q   <= '0;
			stride_q <= 1'b0;
			fill_q   <= 1'b0;
			rem_q    <= '0;
			held_q   <= 8'h00;
			parity_q <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			addr_q   <= addr_d;
			stride_q <= stride_d;
			fill_q   <= fill_d;
			rem_q    <= rem_d;
			held_q   <= held_d;
			parity_q <= parity_d;
		end
	end

endmodule

`default_nettype wire

>>> test/vram_stripe_list_decoder_unit_test.sv
`timescale 1ns / 1ps

module vram_stripe_list_decoder_unit_test;

	localparam int unsigned ADDR_BITS  = 16;
	localparam int          BYTE_COUNT = 650;
	localparam int          QUIET_TAIL = 60;
	localparam int          IDLE_LIMIT = 1000;
	localparam logic [15:0] ADDR_MASK  = 16'((32'd1 << ADDR_BITS) - 1);

	// Expected command stream, built from a private model of the parser.
	class stripe_scoreboard;
		vsld_pkg::phase_t                    phase;
		logic [15:0]                         addr;
		logic                                stride;
		logic                                fill;
		logic [vsld_pkg::REM_BITS-1:0]       remaining;
		logic [7:0]                          held;
		logic                                parity;
		vsld_pkg::result_t                   pending[$];
		int                                  errors;
		int                                  pair_writes;
		int                                  tail_writes;
		int                                  fill_bursts;
		int                                  end_markers;

		function new();
			phase = vsld_pkg::PH_HDR0;
			addr = '0;
			stride = 1'b0;
			fill = 1'b0;
			remaining = '0;
			held = '0;
			parity = 1'b0;
			errors = 0;
			pair_writes = 0;
			tail_writes = 0;
			fill_bursts = 0;
			end_markers = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		function vsld_pkg::result_t make_cmd(logic [15:0] data, logic [1:0] lanes,
				logic [vsld_pkg::COUNT_BITS-1:0] count);
			vsld_pkg::result_t r;
			r = '0;
			r.word_address = addr;
			r.write_data = data;
			r.lane_enable = lanes;
			r.repeat_count = count;
			r.stride_is_32 = stride;
			return r;
		endfunction

		function void step_addr();
			addr = (addr + (stride ? 16'd32 : 16'd1)) & ADDR_MASK;
		endfunction

		function void note_byte(logic [7:0] b);
			vsld_pkg::result_t r;
			logic [15:0] cnt;
			case (phase)
				vsld_pkg::PH_HDR1: begin
					addr = (addr | {8'h00, b}) & ADDR_MASK;
					phase = vsld_pkg::PH_HDR2;
				end
				vsld_pkg::PH_HDR2: begin
					stride = b[vsld_pkg::STRIDE_BIT];
					fill = b[vsld_pkg::FILL_BIT];
					remaining = {1'b0, b[5:0], 8'h00};
					phase = vsld_pkg::PH_HDR3;
				end
				vsld_pkg::PH_HDR3: begin
					remaining = {1'b0, remaining[13:8], b} + 15'd1;
					parity = 1'b0;
					held = '0;
					phase = fill ? vsld_pkg::PH_FILL0 : vsld_pkg::PH_COPY;
				end
				vsld_pkg::PH_COPY: begin
					remaining = remaining - 15'd1;
					if (parity) begin
						pending.push_back(make_cmd({b, held}, vsld_pkg::LANE_BOTH, 14'd1));
						pair_writes++;
						parity = 1'b0;
						step_addr();
						if (remaining == 0)
							phase = vsld_pkg::PH_HDR0;
					end else if (remaining == 0) begin
						// odd tail byte goes out alone on the low lane
						pending.push_back(make_cmd({8'h00, b}, vsld_pkg::LANE_LOW, 14'd1));
						tail_writes++;
						step_addr();
						phase = vsld_pkg::PH_HDR0;
					end else begin
						held = b;
						parity = 1'b1;
					end
				end
				vsld_pkg::PH_FILL0: begin
					held = b;
					parity = 1'b1;
					phase = vsld_pkg::PH_FILL1;
				end
				vsld_pkg::PH_FILL1: begin
					cnt = (16'(remaining) + 16'd1) >> 1;
					pending.push_back(make_cmd({b, held}, vsld_pkg::LANE_BOTH,
						cnt[vsld_pkg::COUNT_BITS-1:0]));
					fill_bursts++;
					parity = 1'b0;
					remaining = '0;
					phase = vsld_pkg::PH_HDR0;
				end
				default: begin
					if (b[vsld_pkg::END_BIT]) begin
						r = '0;
						r.list_done = 1'b1;
						pending.push_back(r);
						end_markers++;
						phase = vsld_pkg::PH_HDR0;
					end else begin
						addr = {b, 8'h00} & ADDR_MASK;
						phase = vsld_pkg::PH_HDR1;
					end
				end
			endcase
		endfunction

		task check_command(vsld_pkg::result_t got);
			vsld_pkg::result_t want;
			if (pending.size() == 0) begin
				report($sformatf("command with nothing expected: %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.word_address !== want.word_address)
				report($sformatf("word_address %h, expected %h",
					got.word_address, want.word_address));
			if (got.write_data !== want.write_data)
				report($sformatf("write_data %h, expected %h",
					got.write_data, want.write_data));
			if (got.lane_enable !== want.lane_enable)
				report($sformatf("lane_enable %b, expected %b",
					got.lane_enable, want.lane_enable));
			if (got.repeat_count !== want.repeat_count)
				report($sformatf("repeat_count %0d, expected %0d",
					got.repeat_count, want.repeat_count));
			if (got.stride_is_32 !== want.stride_is_32)
				report($sformatf("stride_is_32 %b, expected %b",
					got.stride_is_32, want.stride_is_32));
			if (got.list_done !== want.list_done)
				report($sformatf("list_done %b, expected %b",
					got.list_done, want.list_done));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  list_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] word_address;
	logic [15:0] write_data;
	logic [1:0]  lane_enable;
	logic [13:0] repeat_count;
	logic        stride_is_32;
	logic        list_done;

	stripe_scoreboard sb;
	bit quiet;
	int bytes_sent;
	int idle_cycles;

	vram_stripe_list_decoder_unit #(
		.ADDR_BITS(ADDR_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.list_byte(list_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_address(word_address),
		.write_data(write_data),
		.lane_enable(lane_enable),
		.repeat_count(repeat_count),
		.stride_is_32(stride_is_32),
		.list_done(list_done)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		vsld_pkg::result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(list_byte);
			if (out_valid && !out_stall) begin
				got.word_address = word_address;
				got.write_data = write_data;
				got.lane_enable = lane_enable;
				got.repeat_count = repeat_count;
				got.stride_is_32 = stride_is_32;
				got.list_done = list_done;
				sb.check_command(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d commands outstanding",
					IDLE_LIMIT, sb.pending.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// call at a falling edge; returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		list_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [14:0] addr, input logic stride,
			input logic fill, input logic [13:0] len_m1);
		send_byte({1'b0, addr[14:8]});
		send_byte(addr[7:0]);
		send_byte({stride, fill, len_m1[13:8]});
		send_byte(len_m1[7:0]);
	endtask

	task automatic send_random_record();
		logic [14:0] addr;
		logic        stride;
		logic        fill;
		logic [13:0] len_m1;
		addr = 15'($urandom);
		stride = 1'($urandom);
		fill = 1'($urandom);
		if (fill && $urandom_range(0, 3) == 0)
			len_m1 = 14'($urandom);
		else if ($urandom_range(0, 9) == 0)
			len_m1 = 14'($urandom_range(0, 63));
		else
			len_m1 = 14'($urandom_range(0, 15));
		send_header(addr, stride, fill, len_m1);
		if (fill) begin
			send_byte(8'($urandom));
			send_byte(8'($urandom));
		end else begin
			for (int i = 0; i <= len_m1; i++)
				send_byte(8'($urandom));
		end
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		bytes_sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		list_byte = 8'h00;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// end marker straight out of reset, all bits set
		send_byte(8'hFF);
		// two-byte copy at address zero, data extremes
		send_header(15'h0000, 1'b0, 1'b0, 14'd1);
		send_byte(8'hFF);
		send_byte(8'h00);
		// odd copy at the top header address, 32-word stride
		send_header(15'h7FFF, 1'b1, 1'b0, 14'd2);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'hFF);
		// longest fill, stride 32
		send_header(15'h1234, 1'b1, 1'b1, 14'h3FFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		// shortest fill, stride 1
		send_header(15'h4000, 1'b0, 1'b1, 14'd0);
		send_byte(8'hA5);
		send_byte(8'h5A);

		while (bytes_sent < BYTE_COUNT) begin
			if (bytes_sent > BYTE_COUNT - QUIET_TAIL)
				quiet = 1'b1;
			if ($urandom_range(0, 99) < 12)
				send_byte(8'h80 | 8'($urandom_range(0, 127)));
			else
				send_random_record();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d list bytes: %0d full-word copies, %0d odd tail bytes,",
			bytes_sent, sb.pair_writes, sb.tail_writes);
		$display("%0d fill bursts (longest included) and %0d end markers.",
			sb.fill_bursts, sb.end_markers);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
